[hw/rtl/hashed_buffer_cache_directory_macros.svh]
// assertion macros for the buffer cache directory
// no dependencies; included by the top level
`ifndef HASHED_BUFFER_CACHE_DIRECTORY_MACROS_SVH
`define HASHED_BUFFER_CACHE_DIRECTORY_MACROS_SVH

// same-cycle implication
`define HBCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hbcd_pkg.sv]
// types, codes and constants of the buffer cache directory
// no dependencies; used by hashed_buffer_cache_directory
`default_nettype none

package hbcd_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int BUCKETS_DEF = 13;

    localparam int OP_W   = 2;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int IDX_W  = 5;
    localparam int TICK_W = 32;
    localparam int REFS_W = 8;
    localparam int BKT_W  = 6;
    localparam int STS_W  = 2;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_PIN     = 2'd2;
    localparam logic [OP_W-1:0] OP_UNPIN   = 2'd3;

    localparam logic [STS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STS_W-1:0] STS_NOFREE = 2'd1;
    localparam logic [STS_W-1:0] STS_SAT    = 2'd2;

    localparam logic [REFS_W-1:0] REFS_MAX  = '1;
    localparam logic [TICK_W-1:0] STAMP_MAX = '1;

    typedef struct packed {
        logic              dv;
        logic [BKT_W-1:0]  bkt;
        logic [TICK_W-1:0] stamp;
        logic [REFS_W-1:0] refs;
        logic [BLK_W-1:0]  blk;
        logic [DEV_W-1:0]  dev;
    } t_entry;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic             needs_read;
        logic             hit;
        logic [IDX_W-1:0] entry;
    } t_result;

    function automatic logic [TICK_W-1:0] next_stamp(input logic [TICK_W-1:0] tick);
        return (tick == STAMP_MAX) ? STAMP_MAX : tick + 1'b1;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hashed_buffer_cache_directory.sv]
// buffer cache directory: lookup, lru replacement and reference counts
// depends on hbcd_pkg and hashed_buffer_cache_directory_macros.svh
//
// usage:
//   the slave channel takes one request item; tuser carries the opcode
//   (get, release, pin, unpin), tdata the device, block, entry and tick.
//   the master channel returns exactly one result item per request.
//   a get first reduces the block number to its bucket, one byte per cycle,
//   then walks the entry memory one entry per cycle through the
//   single read port, tracking the hit and the oldest free candidates of
//   the bucket and overall; a hit ends the walk early. the hit or chosen
//   free entry is then written back. release, pin and unpin read the
//   entry and write it back; an entry index out of range skips the write.
//   one item is worked on at a time; the next item is accepted as soon as
//   the previous result sits in the output register, even while the
//   receiver stalls it. a stalled result holds until tready.
//   reset empties the directory at once through per-entry valid bits;
//   no clearing pass follows.
`default_nettype none

`include "hashed_buffer_cache_directory_macros.svh"

module hashed_buffer_cache_directory #(
    parameter int ENTRIES = hbcd_pkg::ENTRIES_DEF,
    parameter int BUCKETS = hbcd_pkg::BUCKETS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // device_id, block_number, entry_index, now_tick, zero pad
    input  logic [hbcd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // opcode
    input  logic [hbcd_pkg::S_TUSER_W-1:0]   i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // result_entry, hit, needs_read, status, zero pad
    output logic [hbcd_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int IXW = hbcd_pkg::IDX_W;
    localparam int RW  = hbcd_pkg::BKT_W + 8;
    localparam int PADW = hbcd_pkg::M_TDATA_W - $bits(hbcd_pkg::t_result);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_GWR  = 3'd3;
    localparam logic [2:0] ST_OPRD = 3'd4;
    localparam logic [2:0] ST_OPWR = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] r_state, n_state;

    logic [hbcd_pkg::OP_W-1:0]   r_op;
    logic [hbcd_pkg::DEV_W-1:0]  r_dev;
    logic [hbcd_pkg::BLK_W-1:0]  r_blk;
    logic [hbcd_pkg::BLK_W-1:0]  r_div;
    logic [IXW-1:0]              r_idx;
    logic [hbcd_pkg::TICK_W-1:0] r_stamp;
    logic [hbcd_pkg::BKT_W-1:0]  r_bkt;
    logic [1:0]                  r_byte_cnt;

    logic [IW-1:0] r_addr;
    logic          r_more;
    logic          r_chk;
    logic [IW-1:0] r_cidx;

    logic                        r_lvld;
    logic [IW-1:0]               r_lidx;
    logic [hbcd_pkg::TICK_W-1:0] r_lstamp;
    logic                        r_gvld;
    logic [IW-1:0]               r_gidx;
    logic [hbcd_pkg::TICK_W-1:0] r_gstamp;
    logic                        r_hit;
    logic [IW-1:0]               r_hidx;
    logic [hbcd_pkg::REFS_W-1:0] r_hrefs;
    logic                        r_hdv;

    hbcd_pkg::t_result r_res;
    hbcd_pkg::t_result r_out;
    logic              r_ovld;

    hbcd_pkg::t_entry r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_ent_vld;
    hbcd_pkg::t_entry r_rd_word;
    logic             r_rd_vld;

    logic             s_acc;
    logic             out_load;
    logic [IW-1:0]    rd_addr;
    logic             mem_we;
    logic [IW-1:0]    wr_addr;
    hbcd_pkg::t_entry wr_word;
    hbcd_pkg::t_entry rd_entry;
    hbcd_pkg::t_result res_n;

    logic used, match, lupd, gupd, last, in_range;
    logic [hbcd_pkg::REFS_W-1:0] op_refs;
    logic [hbcd_pkg::STS_W-1:0]  op_sts;

    function automatic logic [hbcd_pkg::BKT_W-1:0] mod_step(
        input logic [hbcd_pkg::BKT_W-1:0] rem,
        input logic [7:0]                 b
    );
        logic [RW-1:0] v;
        v = {rem, b};
        for (int k = 7; k >= 0; k--) begin
            if (v >= (RW'(BUCKETS) << k)) begin
                v = v - (RW'(BUCKETS) << k);
            end
        end
        return v[hbcd_pkg::BKT_W-1:0];
    endfunction

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign out_load   = (r_state == ST_OUT) && (!r_ovld || i_m_tready);
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {{PADW{1'b0}}, r_out};

    assign rd_entry = r_rd_vld ? r_rd_word : '0;
    assign rd_addr  = (r_state == ST_OPRD) ? IW'(r_idx) : r_addr;
    assign in_range = (32'(r_idx) < 32'(ENTRIES));

    // scan compare
    assign used  = (rd_entry.stamp != '0);
    assign match = r_chk && used && (rd_entry.dev == r_dev) && (rd_entry.blk == r_blk);
    assign lupd  = r_chk && !match && (rd_entry.refs == '0) && used &&
                   (rd_entry.bkt == r_bkt) && (!r_lvld || (rd_entry.stamp < r_lstamp));
    assign gupd  = r_chk && !match && (rd_entry.refs == '0) &&
                   (!r_gvld || (rd_entry.stamp < r_gstamp));
    assign last  = (r_cidx == IW'(ENTRIES - 1));

    always_comb begin
        op_refs = rd_entry.refs;
        op_sts  = hbcd_pkg::STS_OK;
        if (r_op == hbcd_pkg::OP_PIN) begin
            if (rd_entry.refs == hbcd_pkg::REFS_MAX) begin
                op_sts = hbcd_pkg::STS_SAT;
            end else begin
                op_refs = rd_entry.refs + 1'b1;
            end
        end else begin
            if (rd_entry.refs == '0) begin
                op_sts = hbcd_pkg::STS_SAT;
            end else begin
                op_refs = rd_entry.refs - 1'b1;
            end
        end
    end

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = r_hidx;
        wr_word = '0;
        res_n   = '0;
        wr_word.dev   = r_dev;
        wr_word.blk   = r_blk;
        wr_word.stamp = r_stamp;
        wr_word.dv    = 1'b1;
        wr_word.bkt   = r_bkt;
        wr_word.refs  = 8'd1;
        unique case (r_state)
            ST_GWR: begin
                if (r_hit) begin
                    mem_we = 1'b1;
                    wr_addr = r_hidx;
                    if (r_hrefs == hbcd_pkg::REFS_MAX) begin
                        wr_word.refs = r_hrefs;
                        res_n.status = hbcd_pkg::STS_SAT;
                    end else begin
                        wr_word.refs = r_hrefs + 1'b1;
                        res_n.status = hbcd_pkg::STS_OK;
                    end
                    res_n.entry      = IXW'(r_hidx);
                    res_n.hit        = 1'b1;
                    res_n.needs_read = !r_hdv;
                end else if (r_lvld || r_gvld) begin
                    mem_we           = 1'b1;
                    wr_addr          = r_lvld ? r_lidx : r_gidx;
                    res_n.entry      = IXW'(wr_addr);
                    res_n.needs_read = 1'b1;
                    res_n.status     = hbcd_pkg::STS_OK;
                end else begin
                    res_n.status = hbcd_pkg::STS_NOFREE;
                end
            end
            ST_OPWR: begin
                mem_we       = 1'b1;
                wr_addr      = IW'(r_idx);
                wr_word      = rd_entry;
                wr_word.refs = op_refs;
                res_n.entry  = r_idx;
                res_n.status = op_sts;
            end
            ST_OPRD: begin
                res_n.entry  = r_idx;
                res_n.status = hbcd_pkg::STS_OK;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = (i_s_tuser == hbcd_pkg::OP_GET) ? ST_MOD : ST_OPRD;
                end
            end
            ST_MOD: begin
                if (r_byte_cnt == 2'd3) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match || (r_chk && last)) begin
                    n_state = ST_GWR;
                end
            end
            ST_GWR:  n_state = ST_OUT;
            ST_OPRD: n_state = in_range ? ST_OPWR : ST_OUT;
            ST_OPWR: n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_word;
        end
        r_rd_word <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_ent_vld[wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_ent_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
            r_chk   <= 1'b0;
            r_more  <= 1'b0;
            r_lvld  <= 1'b0;
            r_gvld  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_chk  <= 1'b0;
                    r_more <= 1'b1;
                    r_lvld <= 1'b0;
                    r_gvld <= 1'b0;
                    r_hit  <= 1'b0;
                end
                ST_SCAN: begin
                    r_chk <= r_more;
                    if (r_more && (r_addr == IW'(ENTRIES - 1))) begin
                        r_more <= 1'b0;
                    end
                    if (match) begin
                        r_hit <= 1'b1;
                    end
                    if (lupd) begin
                        r_lvld <= 1'b1;
                    end
                    if (gupd) begin
                        r_gvld <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op       <= i_s_tuser;
            r_dev      <= i_s_tdata[7:0];
            r_blk      <= i_s_tdata[39:8];
            r_div      <= i_s_tdata[39:8];
            r_idx      <= i_s_tdata[44:40];
            r_stamp    <= hbcd_pkg::next_stamp(i_s_tdata[76:45]);
            r_bkt      <= '0;
            r_byte_cnt <= '0;
            r_addr     <= '0;
        end
        if (r_state == ST_MOD) begin
            r_bkt      <= mod_step(r_bkt, r_div[31:24]);
            r_div      <= {r_div[23:0], 8'h00};
            r_byte_cnt <= r_byte_cnt + 1'b1;
        end
        if (r_state == ST_SCAN) begin
            if (r_more) begin
                r_cidx <= r_addr;
                r_addr <= r_addr + 1'b1;
            end
            if (match) begin
                r_hidx  <= r_cidx;
                r_hrefs <= rd_entry.refs;
                r_hdv   <= rd_entry.dv;
            end
            if (lupd) begin
                r_lidx   <= r_cidx;
                r_lstamp <= rd_entry.stamp;
            end
            if (gupd) begin
                r_gidx   <= r_cidx;
                r_gstamp <= rd_entry.stamp;
            end
        end
        if ((r_state == ST_GWR) || (r_state == ST_OPWR) || (r_state == ST_OPRD)) begin
            r_res <= res_n;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    `HBCD_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, s_acc, r_state != ST_IDLE, "accepted item did not start work")
    `HBCD_ASSERT_IMP(a_hit_has_data, i_clk, i_rst_n, r_ovld && r_out.hit, !r_out.needs_read, "hit on entry without valid data")
    `HBCD_ASSERT_IMP(a_nofree_clean, i_clk, i_rst_n, r_ovld && (r_out.status == hbcd_pkg::STS_NOFREE), !r_out.hit && !r_out.needs_read && (r_out.entry == '0), "no-free result carries entry info")

endmodule

`default_nettype wire

[tb/hbcd_directory_checker.sv]
`timescale 1ns / 1ps
// reply checker of the buffer cache directory: predicts one reply per request item
// depends on hbcd_pkg; instantiated by tb_top beside the block
module hbcd_directory_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // device_id, block_number, entry_index, now_tick, zero pad
    input  logic [hbcd_pkg::S_TDATA_W-1:0] i_s_tdata,
    // opcode
    input  logic [hbcd_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // result_entry, hit, needs_read, status, zero pad
    input  logic [hbcd_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_waiting
);
    import hbcd_pkg::*;

    localparam int N_ENT = ENTRIES_DEF;
    localparam logic [BLK_W-1:0] N_BKT = BUCKETS_DEF;

    logic [DEV_W-1:0]  ent_dev[N_ENT];
    logic [BLK_W-1:0]  ent_blk[N_ENT];
    logic [REFS_W-1:0] ent_refs[N_ENT];
    logic [TICK_W-1:0] ent_stamp[N_ENT];
    logic              ent_dv[N_ENT];

    t_result pending_replies[$];

    // lookup with lru replacement: own bucket first, then oldest free overall
    function automatic t_result serve_get(input logic [DEV_W-1:0] dev,
                                          input logic [BLK_W-1:0] blk,
                                          input logic [TICK_W-1:0] tick);
        t_result r;
        logic [TICK_W-1:0] stamp;
        int hit_at;
        int bucket_at;
        int oldest_at;
        int pick;
        r = '0;
        stamp = (tick == '1) ? tick : tick + 1'b1;
        hit_at = -1;
        bucket_at = -1;
        oldest_at = -1;
        for (int i = 0; i < N_ENT; i++) begin
            if (hit_at < 0) begin
                if (ent_stamp[i] != '0 && ent_dev[i] == dev && ent_blk[i] == blk) begin
                    hit_at = i;
                end else if (ent_refs[i] == '0) begin
                    if (ent_stamp[i] != '0 && (ent_blk[i] % N_BKT) == (blk % N_BKT) &&
                        (bucket_at < 0 || ent_stamp[i] < ent_stamp[bucket_at])) begin
                        bucket_at = i;
                    end
                    if (oldest_at < 0 || ent_stamp[i] < ent_stamp[oldest_at]) begin
                        oldest_at = i;
                    end
                end
            end
        end
        if (hit_at >= 0) begin
            r.entry = hit_at[IDX_W-1:0];
            r.hit = 1'b1;
            r.needs_read = !ent_dv[hit_at];
            if (ent_refs[hit_at] == REFS_MAX) begin
                r.status = STS_SAT;
            end else begin
                ent_refs[hit_at] = ent_refs[hit_at] + 1'b1;
            end
            ent_stamp[hit_at] = stamp;
            ent_dv[hit_at] = 1'b1;
        end else begin
            pick = (bucket_at >= 0) ? bucket_at : oldest_at;
            if (pick < 0) begin
                r.status = STS_NOFREE;
            end else begin
                ent_dev[pick] = dev;
                ent_blk[pick] = blk;
                ent_refs[pick] = REFS_W'(1);
                ent_stamp[pick] = stamp;
                ent_dv[pick] = 1'b1;
                r.entry = pick[IDX_W-1:0];
                r.needs_read = 1'b1;
            end
        end
        return r;
    endfunction

    // release, pin and unpin, saturating at both ends
    function automatic t_result adjust_refs(input logic [OP_W-1:0] op,
                                            input logic [IDX_W-1:0] idx);
        t_result r;
        r = '0;
        r.entry = idx;
        if (op == OP_PIN) begin
            if (ent_refs[idx] == REFS_MAX) begin
                r.status = STS_SAT;
            end else begin
                ent_refs[idx] = ent_refs[idx] + 1'b1;
            end
        end else begin
            if (ent_refs[idx] == '0) begin
                r.status = STS_SAT;
            end else begin
                ent_refs[idx] = ent_refs[idx] - 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_result got;
        t_result want;
        logic [OP_W-1:0] op;
        if (!i_rst_n) begin
            for (int i = 0; i < N_ENT; i++) begin
                ent_dev[i] = '0;
                ent_blk[i] = '0;
                ent_refs[i] = '0;
                ent_stamp[i] = '0;
                ent_dv[i] = 1'b0;
            end
            pending_replies.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_result)-1:0];
                if (pending_replies.size() == 0) begin
                    $error("reply item with no request outstanding: %h", i_m_tdata);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.entry != want.entry) begin
                        $error("result_entry: expected %0d, got %0d", want.entry, got.entry);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.hit != want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.needs_read != want.needs_read) begin
                        $error("needs_read: expected %0d, got %0d",
                               want.needs_read, got.needs_read);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                op = i_s_tuser[OP_W-1:0];
                if (op == OP_GET) begin
                    pending_replies.push_back(serve_get(i_s_tdata[7:0], i_s_tdata[39:8],
                                                        i_s_tdata[76:45]));
                end else begin
                    pending_replies.push_back(adjust_refs(op, i_s_tdata[44:40]));
                end
            end
        end
        o_waiting = pending_replies.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// testbench top of the buffer cache directory: clock, reset, request items and verdict
// depends on hbcd_pkg, hashed_buffer_cache_directory and hbcd_directory_checker
module tb_top;
    import hbcd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL_SIZE = 40;
    localparam int RANDOM_PER_PHASE = 220;
    localparam int PAD_W = S_TDATA_W - DEV_W - BLK_W - IDX_W - TICK_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int waiting;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    logic [TICK_W-1:0] sys_tick = '0;
    logic [DEV_W-1:0] pool_dev[POOL_SIZE];
    logic [BLK_W-1:0] pool_blk[POOL_SIZE];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    hashed_buffer_cache_directory dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    hbcd_directory_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always @(negedge clk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** hashed_buffer_cache_directory: FAILED **");
            $finish;
        end
    end

    // one request item, stamped with the running tick
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DEV_W-1:0] dev,
                             input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(19) == 0) begin
            gap = $urandom_range(1, 45);
        end
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{PAD_W{1'b0}}, sys_tick, idx, blk, dev};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        case ($urandom_range(49))
            0: sys_tick = $urandom;
            1: sys_tick = '1;
            default: sys_tick = sys_tick + $urandom_range(0, 3);
        endcase
    endtask

    task automatic send_random_item();
        int r;
        int k;
        r = $urandom_range(99);
        k = $urandom_range(POOL_SIZE - 1);
        if (r < 40) begin
            if ($urandom_range(4) == 0) begin
                send_item(OP_GET, DEV_W'($urandom_range(255)), $urandom,
                          IDX_W'($urandom_range(31)));
            end else begin
                send_item(OP_GET, pool_dev[k], pool_blk[k], IDX_W'($urandom_range(31)));
            end
        end else if (r < 76) begin
            send_item(OP_RELEASE, DEV_W'($urandom_range(255)), $urandom,
                      IDX_W'($urandom_range(31)));
        end else if (r < 84) begin
            send_item(OP_PIN, DEV_W'($urandom_range(255)), $urandom,
                      IDX_W'($urandom_range(31)));
        end else begin
            send_item(OP_UNPIN, DEV_W'($urandom_range(255)), $urandom,
                      IDX_W'($urandom_range(31)));
        end
    endtask

    initial begin
        // blocks crowded into a few buckets so that bucket reuse is exercised
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_blk[k] = $urandom_range(0, 32'hFFFF_FF00);
            pool_blk[k] = pool_blk[k] - (pool_blk[k] % BUCKETS_DEF) + (k % 6);
            pool_dev[k] = (k % 8 == 0) ? 8'hFF :
                          (k % 3 == 0) ? 8'h00 : DEV_W'($urandom_range(255));
        end
        pool_blk[0] = '0;
        pool_blk[1] = '1;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first get after reset lands in entry 0; drive its count to both ends
        send_item(OP_GET, 8'h5A, 32'd0, 5'd0);
        repeat (254) send_item(OP_PIN, 8'h00, 32'd0, 5'd0);
        send_item(OP_PIN, 8'h00, 32'd0, 5'd0);
        send_item(OP_GET, 8'h5A, 32'd0, 5'd31);
        for (int k = 0; k < 255; k++) begin
            send_item((k % 2) ? OP_RELEASE : OP_UNPIN, 8'hFF, '1, 5'd0);
        end
        send_item(OP_RELEASE, 8'h00, 32'd0, 5'd0);
        send_item(OP_UNPIN, 8'h00, 32'd0, 5'd0);

        // tick at its maximum, block and device extremes
        sys_tick = '1;
        send_item(OP_GET, 8'hFF, '1, 5'd0);
        send_item(OP_GET, 8'hFF, '1, 5'd0);
        send_item(OP_GET, 8'h00, '1, 5'd0);
        send_item(OP_PIN, 8'h00, 32'd0, 5'd31);
        send_item(OP_UNPIN, 8'h00, 32'd0, 5'd31);
        send_item(OP_RELEASE, 8'h00, 32'd0, 5'd31);

        // fill every entry until no free buffer is left, then drain
        for (int k = 0; k < 34; k++) begin
            send_item(OP_GET, 8'h33, 32'h1000 + k, 5'd0);
        end
        for (int k = 0; k < 64; k++) begin
            send_item(OP_RELEASE, 8'h00, 32'd0, IDX_W'(k % 32));
        end
        send_item(OP_GET, 8'h33, 32'h1005, 5'd0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_item();
        end
        s_tvalid <= 1'b0;

        while (waiting != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0) begin
            $display("** hashed_buffer_cache_directory: PASSED **");
        end else begin
            $display("** hashed_buffer_cache_directory: FAILED **");
        end
        $finish;
    end

endmodule
